// File: hdl/jts_pkg.sv
// Shared types, token codes and character classification for the JSON token scanner.
`default_nettype none
package jts_pkg;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_STR  = 2'd1,
        MODE_NUM  = 2'd2,
        MODE_WORD = 2'd3
    } t_mode;

    localparam logic [3:0] TT_LBRACE  = 4'd0;
    localparam logic [3:0] TT_RBRACE  = 4'd1;
    localparam logic [3:0] TT_LBRACK  = 4'd2;
    localparam logic [3:0] TT_RBRACK  = 4'd3;
    localparam logic [3:0] TT_COLON   = 4'd4;
    localparam logic [3:0] TT_COMMA   = 4'd5;
    localparam logic [3:0] TT_STRING  = 4'd6;
    localparam logic [3:0] TT_BOOL    = 4'd7;
    localparam logic [3:0] TT_INT     = 4'd8;
    localparam logic [3:0] TT_ILLEGAL = 4'd9;
    localparam logic [3:0] TT_EOF     = 4'd10;
    localparam logic [3:0] TT_NONE    = 4'd0;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    // Keyword match progress: 1..4 along "true", 5..9 along "false"
    localparam logic [3:0] WM_NONE   = 4'd0;
    localparam logic [3:0] WM_T      = 4'd1;
    localparam logic [3:0] WM_TRUE   = 4'd4;
    localparam logic [3:0] WM_F      = 4'd5;
    localparam logic [3:0] WM_FALSE  = 4'd9;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef enum logic [2:0] {
        CLS_SPACE,
        CLS_PUNCT,
        CLS_QUOTE,
        CLS_EOF,
        CLS_LETTER,
        CLS_DIGIT,
        CLS_OTHER
    } t_cls;

    typedef struct packed {
        logic [3:0] token_type;
        logic [7:0] lit_byte;
        logic       byte_valid;
        logic       token_last;
    } t_result;

    typedef struct packed {
        logic    two;
        t_result r0;
        t_result r1;
    } t_entry;

    typedef struct packed {
        logic not_empty;
        logic full;
    } t_q_status;

    function automatic t_cls classify(input logic [7:0] c);
        t_cls cls;
        if (c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR) begin
            cls = CLS_SPACE;
        end else if (c == CH_LBRACE || c == CH_RBRACE || c == CH_LBRACK ||
                     c == CH_RBRACK || c == CH_COLON || c == CH_COMMA) begin
            cls = CLS_PUNCT;
        end else if (c == CH_QUOTE) begin
            cls = CLS_QUOTE;
        end else if (c == CH_NUL) begin
            cls = CLS_EOF;
        end else if ((c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A)) begin
            cls = CLS_LETTER;
        end else if (c >= 8'h30 && c <= 8'h39) begin
            cls = CLS_DIGIT;
        end else begin
            cls = CLS_OTHER;
        end
        return cls;
    endfunction

    function automatic logic [3:0] punct_type(input logic [7:0] c);
        logic [3:0] t;
        if (c == CH_LBRACE)      t = TT_LBRACE;
        else if (c == CH_RBRACE) t = TT_RBRACE;
        else if (c == CH_LBRACK) t = TT_LBRACK;
        else if (c == CH_RBRACK) t = TT_RBRACK;
        else if (c == CH_COLON)  t = TT_COLON;
        else                     t = TT_COMMA;
        return t;
    endfunction

    function automatic logic [3:0] match_next(input logic [3:0] m, input logic [7:0] c);
        logic [3:0] nm;
        nm = WM_NONE;
        unique case (m)
            4'd1:    if (c == 8'h72) nm = 4'd2;
            4'd2:    if (c == 8'h75) nm = 4'd3;
            4'd3:    if (c == 8'h65) nm = 4'd4;
            4'd5:    if (c == 8'h61) nm = 4'd6;
            4'd6:    if (c == 8'h6C) nm = 4'd7;
            4'd7:    if (c == 8'h73) nm = 4'd8;
            4'd8:    if (c == 8'h65) nm = 4'd9;
            default: nm = WM_NONE;
        endcase
        return nm;
    endfunction

endpackage
`default_nettype wire

// File: hdl/jts_front.sv
// Front end: takes input bytes, tracks the scan mode and builds result entries.
`default_nettype none
module jts_front
    import jts_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_accept,
    input  wire logic [7:0] i_in_byte,
    output      logic       o_push,
    output      t_entry     o_entry
);

    t_mode      r_mode, n_mode;
    logic [3:0] r_match, n_match;

    t_cls       cls;
    t_mode      s_mode;
    logic [3:0] s_match;
    t_result    s_res;
    logic       s_emit;

    // Handling of the byte as the start of a fresh token
    always_comb begin
        cls     = classify(i_in_byte);
        s_mode  = MODE_IDLE;
        s_match = WM_NONE;
        s_emit  = 1'b1;
        s_res   = '{token_type: TT_NONE, lit_byte: i_in_byte, byte_valid: 1'b1,
                    token_last: 1'b0};
        unique case (cls)
            CLS_SPACE: s_emit = 1'b0;
            CLS_PUNCT: begin
                s_res.token_type = punct_type(i_in_byte);
                s_res.token_last = 1'b1;
            end
            CLS_QUOTE: begin
                s_mode = MODE_STR;
                s_emit = 1'b0;
            end
            CLS_EOF: begin
                s_res = '{token_type: TT_EOF, lit_byte: 8'h00, byte_valid: 1'b0,
                          token_last: 1'b1};
            end
            CLS_LETTER: begin
                s_mode  = MODE_WORD;
                s_match = (i_in_byte == 8'h74) ? WM_T :
                          (i_in_byte == 8'h66) ? WM_F : WM_NONE;
            end
            CLS_DIGIT: s_mode = MODE_NUM;
            CLS_OTHER: begin
                s_res.token_type = TT_ILLEGAL;
                s_res.token_last = 1'b1;
            end
            default: s_emit = 1'b0;
        endcase
    end

    // Next state
    always_comb begin
        n_mode  = r_mode;
        n_match = r_match;
        if (i_accept) begin
            unique case (r_mode)
                MODE_IDLE: begin
                    n_mode  = s_mode;
                    n_match = s_match;
                end
                MODE_STR: begin
                    if (cls == CLS_QUOTE) begin
                        n_mode = MODE_IDLE;
                    end else if (cls == CLS_EOF) begin
                        n_mode  = MODE_IDLE;
                        n_match = WM_NONE;
                    end
                end
                MODE_NUM: begin
                    if (cls != CLS_DIGIT) begin
                        n_mode  = s_mode;
                        n_match = s_match;
                    end
                end
                MODE_WORD: begin
                    if (cls == CLS_LETTER) begin
                        n_match = match_next(r_match, i_in_byte);
                    end else begin
                        n_mode  = s_mode;
                        n_match = s_match;
                    end
                end
                default: n_mode = MODE_IDLE;
            endcase
        end
    end

    // Outputs: one or two results per beat, none for skipped bytes
    always_comb begin
        t_result lit_res;
        t_result end_res;
        logic    emit;
        lit_res = '{token_type: TT_NONE, lit_byte: i_in_byte, byte_valid: 1'b1,
                    token_last: 1'b0};
        end_res = '{token_type: TT_NONE, lit_byte: 8'h00, byte_valid: 1'b0,
                    token_last: 1'b1};
        emit    = 1'b1;
        o_entry = '{two: 1'b0, r0: lit_res, r1: s_res};
        unique case (r_mode)
            MODE_IDLE: begin
                emit       = s_emit;
                o_entry.r0 = s_res;
            end
            MODE_STR: begin
                if (cls == CLS_QUOTE) begin
                    end_res.token_type = TT_STRING;
                    o_entry.r0         = end_res;
                end else if (cls == CLS_EOF) begin
                    end_res.token_type = TT_ILLEGAL;
                    o_entry.r0         = end_res;
                    o_entry.two        = 1'b1;
                end
            end
            MODE_NUM: begin
                if (cls != CLS_DIGIT) begin
                    end_res.token_type = TT_INT;
                    o_entry.r0         = end_res;
                    o_entry.two        = s_emit;
                end
            end
            MODE_WORD: begin
                if (cls != CLS_LETTER) begin
                    end_res.token_type = (r_match == WM_TRUE || r_match == WM_FALSE) ?
                                         TT_BOOL : TT_ILLEGAL;
                    o_entry.r0         = end_res;
                    o_entry.two        = s_emit;
                end
            end
            default: emit = 1'b0;
        endcase
        o_push = i_accept && emit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_match <= WM_NONE;
        end else begin
            r_mode  <= n_mode;
            r_match <= n_match;
        end
    end

endmodule
`default_nettype wire

// File: hdl/jts_queue.sv
// Short entry queue between the front end and the output stage.
`default_nettype none
module jts_queue
    import jts_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_push,
    input  wire t_entry    i_entry,
    input  wire logic      i_pop,
    output      t_q_status o_status,
    output      t_entry    o_head
);

    t_entry               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [Q_PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [Q_CNT_W-1:0]   r_count, n_count;

    assign o_status.not_empty = (r_count != '0);
    assign o_status.full      = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_head             = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) n_wr_ptr = r_wr_ptr + 1'b1;
        if (i_pop)  n_rd_ptr = r_rd_ptr + 1'b1;
        if (i_push && !i_pop)      n_count = r_count + 1'b1;
        else if (!i_push && i_pop) n_count = r_count - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_entry;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule
`default_nettype wire

// File: hdl/jts_back.sv
// Output stage: unpacks queue entries into single result beats.
`default_nettype none
module jts_back
    import jts_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_q_status i_status,
    input  wire t_entry    i_head,
    input  wire logic      i_stall,
    output      logic      o_pop,
    output      logic      o_valid,
    output      t_result   o_res
);

    logic    r_valid, n_valid;
    logic    r_second, n_second;
    t_result r_res, n_res;
    logic    load;

    assign load = (!r_valid || !i_stall) && i_status.not_empty;

    always_comb begin
        n_valid  = r_valid && i_stall;
        n_second = r_second;
        n_res    = r_res;
        o_pop    = 1'b0;
        if (load) begin
            n_valid = 1'b1;
            n_res   = r_second ? i_head.r1 : i_head.r0;
            // Hold the entry for its second result, else drop it
            if (i_head.two && !r_second) begin
                n_second = 1'b1;
            end else begin
                n_second = 1'b0;
                o_pop    = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_second <= 1'b0;
        end else begin
            r_valid  <= n_valid;
            r_second <= n_second;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule
`default_nettype wire

// File: hdl/json_token_scanner.sv
// Top level of the JSON token scanner: front end, entry queue and output stage.
//
//  channel  | valid    | stall    | payload
//  ---------+----------+----------+-------------------------------------------------
//  input    | i_valid  | o_stall  | i_in_byte
//  result   | o_valid  | i_stall  | o_token_type, o_lit_byte, o_byte_valid, o_token_last
//
// One byte is taken per cycle while the four-entry queue has room; each byte
// leaves 0, 1 or 2 results, and the output register sends one result a cycle
// while i_stall is low, so an entry with two results stays at the queue head until both are sent.
// A result passes through the queue and then the output register.
// Reset (synchronous, active low) empties the queue and returns the scanner to idle.
// A stalled output holds its result; the queue absorbs bytes until it fills.
`default_nettype none
module json_token_scanner
    import jts_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output      logic       o_stall,
    input  wire logic [7:0] i_in_byte,
    output      logic       o_valid,
    input  wire logic       i_stall,
    output      logic [3:0] o_token_type,
    output      logic [7:0] o_lit_byte,
    output      logic       o_byte_valid,
    output      logic       o_token_last
);

    t_q_status q_status;
    t_entry    push_entry;
    t_entry    head;
    t_result   res;
    logic      accept;
    logic      push;
    logic      pop;

    assign o_stall = q_status.full;
    assign accept  = i_valid && !q_status.full;

    jts_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_in_byte (i_in_byte),
        .o_push    (push),
        .o_entry   (push_entry)
    );

    jts_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_entry  (push_entry),
        .i_pop    (pop),
        .o_status (q_status),
        .o_head   (head)
    );

    jts_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (q_status),
        .i_head   (head),
        .i_stall  (i_stall),
        .o_pop    (pop),
        .o_valid  (o_valid),
        .o_res    (res)
    );

    assign o_token_type = res.token_type;
    assign o_lit_byte   = res.lit_byte;
    assign o_byte_valid = res.byte_valid;
    assign o_token_last = res.token_last;

    a_eof_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_token_type == TT_EOF) |-> (o_token_last && !o_byte_valid))
        else $error("eof result without token_last or with a literal");

    a_type_only_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_token_last) |-> (o_token_type == TT_NONE && o_byte_valid))
        else $error("inner result carries a token type or no literal");

    a_lit_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_byte_valid) |-> (o_lit_byte == 8'h00))
        else $error("literal byte set while byte_valid is low");

    a_pop_needs_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> (q_status.not_empty && (!o_valid || !i_stall)))
        else $error("queue popped while empty or while output stalled");

endmodule
`default_nettype wire
